// File: hw/rtl/tbi_pkg.sv
package tbi_pkg;

	// Request types carried on req_type.
	localparam logic [1:0] REQ_WR_SLEW = 2'd0;
	localparam logic [1:0] REQ_WR_LOAD = 2'd1;
	localparam logic [1:0] REQ_WR_VAL  = 2'd2;
	localparam logic [1:0] REQ_QUERY   = 2'd3;

	// Status codes returned with each query result.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_SLEW_OOR = 2'd1;
	localparam logic [1:0] STAT_LOAD_OOR = 2'd2;
	localparam logic [1:0] STAT_ZERO_INT = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_SLEW_COUNT = 1'b0;
	localparam logic CFG_LOAD_COUNT = 1'b1;

	// Signed accumulator and magnitude numerator widths.
	localparam int ACC_W = 98;
	localparam int NUM_W = 97;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENDS,
		ST_ENDS2,
		ST_CHECK,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_PT1,
		ST_PT2,
		ST_DIFF,
		ST_DEN,
		ST_T_RD,
		ST_T_M1,
		ST_T_M2,
		ST_T_ACC,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/tbi_ram.sv
module tbi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/table_bilinear_interpolator.sv
// Bilinear lookup in a two-dimensional characterization table (slew axis by load axis,
// signed Q16.16). Requests of type 0, 1 and 2 write an axis point or a table value and
// are taken without a result. A query request produces one result: the
// interpolated value, rounded to nearest and saturated, with a status code. All
// arithmetic runs through a single 32x32 multiplier and a restoring divider that
// produces one quotient bit per cycle, under a small sequencer; the block accepts no
// request while a query is in progress. The division works on the 97-bit numerator,
// and each axis search reads and compares one breakpoint at a time. An out-of-range
// query skips the search and the arithmetic. The next request is taken in the cycle
// after the result is loaded. Configuration is taken on any cycle while idle.
module table_bilinear_interpolator
	import tbi_pkg::*;
#(
	parameter int MAX_AXIS_POINTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [2:0]         row_index,
	input  logic [2:0]         col_index,
	input  logic signed [31:0] write_value,
	input  logic signed [31:0] slew_in,
	input  logic signed [31:0] load_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] interp_value,
	output logic [1:0]         status_code
);

	localparam int IW = $clog2(MAX_AXIS_POINTS);
	localparam int TD = MAX_AXIS_POINTS * MAX_AXIS_POINTS;
	localparam int TW = $clog2(TD);
	localparam int CW = $clog2(MAX_AXIS_POINTS + 1);

	state_t state_q, state_nxt;

	logic [3:0] slew_cnt_q, load_cnt_q;
	logic [CW-1:0] ns, nl;

	logic in_acc;
	logic [4:0] row_w, col_w;
	logic [9:0] taddr_w;

	logic slew_we, load_we, tab_we;
	logic [IW-1:0] slew_raddr, load_raddr;
	logic [TW-1:0] tab_raddr;
	logic [31:0] slew_rd, load_rd, tab_rd;

	logic signed [31:0] x_q, y_q, slew_lo_q, load_lo_q, x1_q, y1_q;
	logic [CW-1:0] idx_q;
	logic sel_q;
	logic [IW-1:0] si_q, li_q;
	logic [31:0] xa_q, xb_q, ya_q, yb_q, dxm_q, dym_q;
	logic xa_s_q, xb_s_q, ya_s_q, yb_s_q, dxs_q, dys_q;
	logic [1:0] k_q;
	logic [63:0] den_q, p_q;
	logic [31:0] qm_q;
	logic tneg_q;
	logic [95:0] t_q;
	logic [ACC_W-1:0] acc_q;
	logic [NUM_W-1:0] num_q;
	logic [63:0] rem_q;
	logic [32:0] quo_q;
	logic ovf_q, qneg_q;
	logic [6:0] cnt_q;
	logic signed [31:0] res_q;
	logic [1:0] stat_q;
	logic out_valid_q;
	logic signed [31:0] out_val_q;
	logic [1:0] out_stat_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	// Scan, range and difference helpers.
	logic signed [31:0] scan_v, scan_rd;
	logic scan_le, scan_stop;
	logic [CW-1:0] idx_inc, low_raw, low_clamp, scan_n;
	logic slew_oor, load_oor;
	logic [32:0] d_xa, d_xb, d_ya, d_yb, d_dx, d_dy;
	logic [64:0] rem2, rem2_sub;
	logic div_bit;
	logic [64:0] rem_dbl;
	logic [33:0] quo_rnd, lim;
	logic [31:0] res_mag;
	logic sat;

	function automatic logic [31:0] mag33(input logic [32:0] d);
		logic [32:0] n;
		n = d[32] ? (33'd0 - d) : d;
		return n[31:0];
	endfunction

	function automatic logic [CW-1:0] eff_count(input logic [3:0] c);
		logic [4:0] cx;
		cx = {1'b0, c};
		if (cx < 5'd2) begin
			return CW'(2);
		end else if (32'(cx) > MAX_AXIS_POINTS) begin
			return CW'(MAX_AXIS_POINTS);
		end
		return CW'(cx);
	endfunction

	assign ns = eff_count(slew_cnt_q);
	assign nl = eff_count(load_cnt_q);

	// Request handshake: requests are taken only while idle.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// Write decode for the three stores; indexes beyond the table are dropped.
	assign row_w   = {2'b00, row_index};
	assign col_w   = {2'b00, col_index};
	assign taddr_w = 10'(row_w * MAX_AXIS_POINTS) + 10'(col_w);
	assign slew_we = in_acc && (req_type == REQ_WR_SLEW) && (32'(row_w) < MAX_AXIS_POINTS);
	assign load_we = in_acc && (req_type == REQ_WR_LOAD) && (32'(row_w) < MAX_AXIS_POINTS);
	assign tab_we  = in_acc && (req_type == REQ_WR_VAL) && (32'(row_w) < MAX_AXIS_POINTS)
		&& (32'(col_w) < MAX_AXIS_POINTS);

	tbi_ram #(.WIDTH(32), .DEPTH(MAX_AXIS_POINTS)) u_slew_ram (
		.clk(clk), .we(slew_we), .waddr(row_w[IW-1:0]), .wdata(write_value),
		.raddr(slew_raddr), .rdata(slew_rd)
	);

	tbi_ram #(.WIDTH(32), .DEPTH(MAX_AXIS_POINTS)) u_load_ram (
		.clk(clk), .we(load_we), .waddr(row_w[IW-1:0]), .wdata(write_value),
		.raddr(load_raddr), .rdata(load_rd)
	);

	tbi_ram #(.WIDTH(32), .DEPTH(TD)) u_tab_ram (
		.clk(clk), .we(tab_we), .waddr(taddr_w[TW-1:0]), .wdata(write_value),
		.raddr(tab_raddr), .rdata(tab_rd)
	);

	// Shared multiplier.
	assign mul_p = mul_a * mul_b;

	// Axis scan compare and lower-point selection.
	assign scan_v    = sel_q ? y_q : x_q;
	assign scan_rd   = sel_q ? $signed(load_rd) : $signed(slew_rd);
	assign scan_n    = sel_q ? nl : ns;
	assign scan_le   = (scan_rd <= scan_v);
	assign idx_inc   = idx_q + CW'(1);
	assign scan_stop = !scan_le || (idx_inc == scan_n);
	always_comb begin
		logic [CW-1:0] cnt_end;
		cnt_end   = scan_le ? idx_inc : idx_q;
		low_raw   = (cnt_end != '0) ? (cnt_end - CW'(1)) : '0;
		low_clamp = (low_raw > (scan_n - CW'(2))) ? (scan_n - CW'(2)) : low_raw;
	end

	// Range checks against the axis ends.
	assign slew_oor = (x_q < slew_lo_q) || (x_q > $signed(slew_rd));
	assign load_oor = (y_q < load_lo_q) || (y_q > $signed(load_rd));

	// Interval differences, formed when the upper points arrive.
	assign d_xa = {slew_rd[31], slew_rd} - {x_q[31], x_q};
	assign d_xb = {x_q[31], x_q} - {x1_q[31], x1_q};
	assign d_ya = {load_rd[31], load_rd} - {y_q[31], y_q};
	assign d_yb = {y_q[31], y_q} - {y1_q[31], y1_q};
	assign d_dx = {slew_rd[31], slew_rd} - {x1_q[31], x1_q};
	assign d_dy = {load_rd[31], load_rd} - {y1_q[31], y1_q};

	// One restoring division step.
	assign div_bit  = num_q[NUM_W-1];
	assign rem2     = {rem_q, div_bit};
	assign rem2_sub = rem2 - {1'b0, den_q};

	// Rounding and saturation of the final quotient.
	assign rem_dbl = {rem_q, 1'b0};
	assign quo_rnd = {1'b0, quo_q} + ((rem_dbl >= {1'b0, den_q}) ? 34'd1 : 34'd0);
	assign lim     = qneg_q ? 34'h080000000 : 34'h07FFFFFFF;
	assign sat     = ovf_q || (quo_rnd > lim);
	assign res_mag = sat ? lim[31:0] : quo_rnd[31:0];

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (req_type == REQ_QUERY)) begin
					state_nxt = ST_ENDS;
				end
			end
			ST_ENDS:  state_nxt = ST_ENDS2;
			ST_ENDS2: state_nxt = ST_CHECK;
			ST_CHECK: begin
				state_nxt = (slew_oor || load_oor) ? ST_DONE : ST_SCAN_RD;
			end
			ST_SCAN_RD: state_nxt = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (!scan_stop) begin
					state_nxt = ST_SCAN_RD;
				end else begin
					state_nxt = sel_q ? ST_PT1 : ST_SCAN_RD;
				end
			end
			ST_PT1: state_nxt = ST_PT2;
			ST_PT2: state_nxt = ST_DIFF;
			ST_DIFF: begin
				state_nxt = ((d_dx == '0) || (d_dy == '0)) ? ST_DONE : ST_DEN;
			end
			ST_DEN:   state_nxt = ST_T_RD;
			ST_T_RD:  state_nxt = ST_T_M1;
			ST_T_M1:  state_nxt = ST_T_M2;
			ST_T_M2:  state_nxt = ST_T_ACC;
			ST_T_ACC: state_nxt = (k_q == 2'd3) ? ST_DIV : ST_T_RD;
			ST_DIV:   state_nxt = (cnt_q == 7'(NUM_W)) ? ST_DONE : ST_DIV;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Memory addresses and multiplier operands per state.
	always_comb begin
		logic [4:0] trow, tcol;
		logic [9:0] taddr;
		trow       = 5'(si_q) + {4'd0, k_q[0]};
		tcol       = 5'(li_q) + {4'd0, k_q[1]};
		taddr      = 10'(trow * MAX_AXIS_POINTS) + 10'(tcol);
		slew_raddr = '0;
		load_raddr = '0;
		tab_raddr  = taddr[TW-1:0];
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			ST_ENDS2: begin
				slew_raddr = IW'(ns - CW'(1));
				load_raddr = IW'(nl - CW'(1));
			end
			ST_SCAN_RD: begin
				slew_raddr = idx_q[IW-1:0];
				load_raddr = idx_q[IW-1:0];
			end
			ST_PT1: begin
				slew_raddr = si_q;
				load_raddr = li_q;
			end
			ST_PT2: begin
				slew_raddr = si_q + IW'(1);
				load_raddr = li_q + IW'(1);
			end
			ST_DEN: begin
				mul_a = dxm_q;
				mul_b = dym_q;
			end
			ST_T_RD: begin
				mul_a = k_q[0] ? xb_q : xa_q;
				mul_b = k_q[1] ? yb_q : ya_q;
			end
			ST_T_M1: begin
				mul_a = p_q[31:0];
				mul_b = tab_rd[31] ? (32'd0 - tab_rd) : tab_rd;
			end
			ST_T_M2: begin
				mul_a = p_q[63:32];
				mul_b = qm_q;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slew_cnt_q  <= 4'd2;
			load_cnt_q  <= 4'd2;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				if (cfg_index == CFG_SLEW_COUNT) begin
					slew_cnt_q <= cfg_wdata;
				end else begin
					load_cnt_q <= cfg_wdata;
				end
			end
			if ((state_q == ST_DONE) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= slew_in;
				y_q <= load_in;
			end
			ST_ENDS2: begin
				slew_lo_q <= $signed(slew_rd);
				load_lo_q <= $signed(load_rd);
			end
			ST_CHECK: begin
				res_q  <= '0;
				stat_q <= slew_oor ? STAT_SLEW_OOR : STAT_LOAD_OOR;
				idx_q  <= '0;
				sel_q  <= 1'b0;
			end
			ST_SCAN_CMP: begin
				if (!scan_stop) begin
					idx_q <= idx_inc;
				end else begin
					if (sel_q) begin
						li_q <= low_clamp[IW-1:0];
					end else begin
						si_q <= low_clamp[IW-1:0];
					end
					idx_q <= '0;
					sel_q <= 1'b1;
				end
			end
			ST_PT2: begin
				x1_q <= $signed(slew_rd);
				y1_q <= $signed(load_rd);
			end
			ST_DIFF: begin
				xa_q   <= mag33(d_xa);
				xa_s_q <= d_xa[32];
				xb_q   <= mag33(d_xb);
				xb_s_q <= d_xb[32];
				ya_q   <= mag33(d_ya);
				ya_s_q <= d_ya[32];
				yb_q   <= mag33(d_yb);
				yb_s_q <= d_yb[32];
				dxm_q  <= mag33(d_dx);
				dxs_q  <= d_dx[32];
				dym_q  <= mag33(d_dy);
				dys_q  <= d_dy[32];
				res_q  <= '0;
				stat_q <= STAT_ZERO_INT;
				k_q    <= '0;
				acc_q  <= '0;
			end
			ST_DEN: begin
				den_q <= mul_p;
			end
			ST_T_RD: begin
				p_q    <= mul_p;
				tneg_q <= (k_q[0] ? xb_s_q : xa_s_q) ^ (k_q[1] ? yb_s_q : ya_s_q);
			end
			ST_T_M1: begin
				t_q    <= {32'd0, mul_p};
				qm_q   <= mul_b;
				tneg_q <= tneg_q ^ tab_rd[31];
			end
			ST_T_M2: begin
				t_q <= t_q + {mul_p, 32'd0};
			end
			ST_T_ACC: begin
				if (k_q == 2'd3) begin
					// Last term: form the signed sum and start the division on its magnitude.
					logic [ACC_W-1:0] sum;
					logic [ACC_W-1:0] mag;
					sum = tneg_q ? (acc_q - {2'b00, t_q}) : (acc_q + {2'b00, t_q});
					mag = sum[ACC_W-1] ? (ACC_W'(0) - sum) : sum;
					num_q  <= mag[NUM_W-1:0];
					qneg_q <= sum[ACC_W-1] ^ dxs_q ^ dys_q;
					rem_q  <= '0;
					quo_q  <= '0;
					ovf_q  <= 1'b0;
					cnt_q  <= '0;
				end else begin
					acc_q <= tneg_q ? (acc_q - {2'b00, t_q}) : (acc_q + {2'b00, t_q});
				end
				k_q <= k_q + 2'd1;
			end
			ST_DIV: begin
				if (cnt_q != 7'(NUM_W)) begin
					num_q <= {num_q[NUM_W-2:0], 1'b0};
					ovf_q <= ovf_q | quo_q[32];
					if (!rem2_sub[64]) begin
						rem_q <= rem2_sub[63:0];
						quo_q <= {quo_q[31:0], 1'b1};
					end else begin
						rem_q <= rem2[63:0];
						quo_q <= {quo_q[31:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
				end else begin
					res_q  <= qneg_q ? (32'sd0 - $signed(res_mag)) : $signed(res_mag);
					stat_q <= STAT_OK;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_val_q  <= res_q;
					out_stat_q <= stat_q;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign interp_value = out_val_q;
	assign status_code  = out_stat_q;

endmodule

// File: test/tb_table_bilinear_interpolator.sv
module tb_table_bilinear_interpolator;
	import tbi_pkg::*;

	localparam int NPTS = 8;
	localparam int SETTLE_CYCLES = 250;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		logic [1:0]         kind;
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [31:0] wv;
		logic signed [31:0] sx;
		logic signed [31:0] ld;
	} request_t;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
	} lookup_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic               cfg_index = CFG_SLEW_COUNT;
	logic [3:0]         cfg_wdata = 4'd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type = REQ_WR_SLEW;
	logic [2:0]         row_index = 3'd0;
	logic [2:0]         col_index = 3'd0;
	logic signed [31:0] write_value = 32'sd0;
	logic signed [31:0] slew_in = 32'sd0;
	logic signed [31:0] load_in = 32'sd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] interp_value;
	logic [1:0]         status_code;

	table_bilinear_interpolator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.row_index   (row_index),
		.col_index   (col_index),
		.write_value (write_value),
		.slew_in     (slew_in),
		.load_in     (load_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.interp_value(interp_value),
		.status_code (status_code)
	);

	request_t pending_requests[$];
	lookup_t  expected_lookups[$];
	int       errors = 0;
	int       cycles = 0;
	bit       no_gaps = 1'b0;

	// Mirror of the table contents and point counts.
	logic signed [31:0] mdl_slew[NPTS];
	logic signed [31:0] mdl_load[NPTS];
	logic signed [31:0] mdl_tbl[NPTS*NPTS];
	logic [3:0]         mdl_slew_cnt = 4'd2;
	logic [3:0]         mdl_load_cnt = 4'd2;

	// What the stimulus side has written to the axes.
	logic signed [31:0] gen_slew[NPTS];
	logic signed [31:0] gen_load[NPTS];
	int                 gen_ns = 2;
	int                 gen_nl = 2;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int eff_count(logic [3:0] c);
		if (c < 2) return 2;
		if (c > NPTS) return NPTS;
		return int'(c);
	endfunction

	// The lower point sits just before the first point above the input, clamped to n-2.
	function automatic int lower_point(logic signed [31:0] ax[NPTS], int n, logic signed [31:0] v);
		int i;
		i = 0;
		while (i < n && ax[i] <= v) i++;
		if (i > 0) i--;
		if (i > n - 2) i = n - 2;
		return i;
	endfunction

	// Apply one accepted request to the mirror and queue the lookup result it yields.
	function automatic void predict_lookup(request_t r);
		int ns, nl, si, li;
		logic signed [131:0] x, y, x1, x2, y1, y2, dx, dy, acc, den;
		logic [131:0] nmag, dmag, quo, rmd, lim;
		logic neg;
		lookup_t res;
		res.value = 32'sd0;
		res.status = STAT_OK;
		case (r.kind)
			REQ_WR_SLEW: mdl_slew[r.row] = r.wv;
			REQ_WR_LOAD: mdl_load[r.row] = r.wv;
			REQ_WR_VAL: mdl_tbl[r.row*NPTS + r.col] = r.wv;
			default: begin
				ns = eff_count(mdl_slew_cnt);
				nl = eff_count(mdl_load_cnt);
				if (r.sx < mdl_slew[0] || r.sx > mdl_slew[ns-1]) begin
					res.status = STAT_SLEW_OOR;
				end else if (r.ld < mdl_load[0] || r.ld > mdl_load[nl-1]) begin
					res.status = STAT_LOAD_OOR;
				end else begin
					si = lower_point(mdl_slew, ns, r.sx);
					li = lower_point(mdl_load, nl, r.ld);
					x = r.sx;
					y = r.ld;
					x1 = mdl_slew[si];
					x2 = mdl_slew[si+1];
					y1 = mdl_load[li];
					y2 = mdl_load[li+1];
					dx = x2 - x1;
					dy = y2 - y1;
					if (dx == 0 || dy == 0) begin
						res.status = STAT_ZERO_INT;
					end else begin
						acc = mdl_tbl[si*NPTS+li] * (x2 - x) * (y2 - y)
							+ mdl_tbl[(si+1)*NPTS+li] * (x - x1) * (y2 - y)
							+ mdl_tbl[si*NPTS+li+1] * (x2 - x) * (y - y1)
							+ mdl_tbl[(si+1)*NPTS+li+1] * (x - x1) * (y - y1);
						den = dx * dy;
						neg = (acc < 0) != (den < 0);
						nmag = (acc < 0) ? -acc : acc;
						dmag = (den < 0) ? -den : den;
						quo = nmag / dmag;
						rmd = nmag % dmag;
						// Round half away from zero, then saturate.
						if (rmd >= dmag - rmd) quo = quo + 1;
						lim = neg ? 132'h80000000 : 132'h7fffffff;
						if (quo > lim) quo = lim;
						if (neg) quo = -quo;
						res.value = quo[31:0];
					end
				end
				expected_lookups = {expected_lookups, res};
			end
		endcase
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Request driver.
	int       send_gap = 0;
	request_t cur_req;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) predict_lookup(cur_req);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					cur_req = pending_requests.pop_front();
					req_type <= cur_req.kind;
					row_index <= cur_req.row;
					col_index <= cur_req.col;
					write_value <= cur_req.wv;
					slew_in <= cur_req.sx;
					load_in <= cur_req.ld;
					in_valid <= 1'b1;
					send_gap = idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	int stall_left = 0;
	always @(posedge clk) begin
		lookup_t exp_res;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_lookups.size() == 0) begin
					errors++;
					$display("%0t: unexpected result value %0d status %0d",
						$time, interp_value, status_code);
				end else begin
					exp_res = expected_lookups.pop_front();
					if (interp_value !== exp_res.value) begin
						errors++;
						$display("%0t: interp_value expected %0d actual %0d",
							$time, exp_res.value, interp_value);
					end
					if (status_code !== exp_res.status) begin
						errors++;
						$display("%0t: status_code expected %0d actual %0d",
							$time, exp_res.status, status_code);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = idle_len();
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_req(logic [1:0] kind, logic [2:0] row, logic [2:0] col,
		logic signed [31:0] wv, logic signed [31:0] sx, logic signed [31:0] ld);
		request_t r;
		r.kind = kind;
		r.row = row;
		r.col = col;
		r.wv = wv;
		r.sx = sx;
		r.ld = ld;
		pending_requests = {pending_requests, r};
	endtask

	task automatic push_query(logic signed [31:0] sx, logic signed [31:0] ld);
		push_req(REQ_QUERY, 3'($urandom), 3'($urandom), $urandom, sx, ld);
	endtask

	task automatic wait_idle();
		while (pending_requests.size() > 0 || in_valid || expected_lookups.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_counts(logic [3:0] s, logic [3:0] l);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_SLEW_COUNT;
		cfg_wdata <= s;
		mdl_slew_cnt = s;
		@(posedge clk);
		cfg_index <= CFG_LOAD_COUNT;
		cfg_wdata <= l;
		mdl_load_cnt = l;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gen_ns = eff_count(s);
		gen_nl = eff_count(l);
	endtask

	// Eight axis points, usually ascending, sometimes with repeats or full-range ends.
	task automatic make_axis(output logic signed [31:0] pts[NPTS], input bit sorted);
		int vals[$];
		int sh;
		sh = $urandom_range(0, 16);
		for (int k = 0; k < NPTS; k++) vals = {vals, $signed($urandom) >>> sh};
		if (sorted) begin
			vals.sort();
			if ($urandom_range(0, 7) == 0) begin
				vals[0] = 32'sh80000000;
				vals[NPTS-1] = 32'sh7fffffff;
			end
		end
		for (int k = 1; k < NPTS; k++)
			if ($urandom_range(0, 19) == 0) vals[k] = vals[k-1];
		for (int k = 0; k < NPTS; k++) pts[k] = vals[k];
	endtask

	function automatic logic signed [31:0] pick_between(logic signed [31:0] lo,
		logic signed [31:0] hi);
		longint span;
		longint unsigned r;
		span = longint'(hi) - longint'(lo);
		if (span < 0) return $urandom;
		r = {$urandom, $urandom};
		return 32'(longint'(lo) + longint'(r % longint'(span + 1)));
	endfunction

	function automatic logic signed [31:0] table_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			default: return $signed($urandom) >>> $urandom_range(0, 20);
		endcase
	endfunction

	task automatic push_random_query();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			push_query(pick_between(gen_slew[0], gen_slew[gen_ns-1]),
				pick_between(gen_load[0], gen_load[gen_nl-1]));
		else if (r == 7)
			push_query(gen_slew[$urandom_range(0, gen_ns-1)],
				gen_load[$urandom_range(0, gen_nl-1)]);
		else
			push_query($urandom, $urandom);
	endtask

	task automatic run_phase(logic [3:0] s, logic [3:0] l, bit fill_all);
		bit sorted;
		wait_idle();
		write_counts(s, l);
		no_gaps = ($urandom_range(0, 3) == 0);
		sorted = ($urandom_range(0, 4) != 0);
		make_axis(gen_slew, sorted);
		make_axis(gen_load, sorted);
		for (int k = 0; k < NPTS; k++) begin
			push_req(REQ_WR_SLEW, 3'(k), 3'($urandom), gen_slew[k], $urandom, $urandom);
			push_req(REQ_WR_LOAD, 3'(k), 3'($urandom), gen_load[k], $urandom, $urandom);
		end
		if (fill_all) begin
			for (int k = 0; k < NPTS*NPTS; k++)
				push_req(REQ_WR_VAL, 3'(k / NPTS), 3'(k % NPTS), table_value(),
					$urandom, $urandom);
		end else begin
			repeat (12)
				push_req(REQ_WR_VAL, 3'($urandom), 3'($urandom), table_value(),
					$urandom, $urandom);
		end
		repeat (75) begin
			if ($urandom_range(0, 5) == 0)
				push_req(REQ_WR_VAL, 3'($urandom), 3'($urandom), table_value(),
					$urandom, $urandom);
			else
				push_random_query();
		end
	endtask

	// Stimulus sequence.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset counts of two points per axis.
		push_req(REQ_WR_SLEW, 0, 0, 32'sh00010000, 0, 0);
		push_req(REQ_WR_SLEW, 1, 7, 32'sh00030000, 0, 0);
		push_req(REQ_WR_LOAD, 0, 0, -32'sh00020000, 0, 0);
		push_req(REQ_WR_LOAD, 1, 0, 32'sh00020000, 0, 0);
		push_req(REQ_WR_VAL, 0, 0, 32'sh7fffffff, 0, 0);
		push_req(REQ_WR_VAL, 1, 0, 32'sh80000000, 0, 0);
		push_req(REQ_WR_VAL, 0, 1, 32'sh12345678, 0, 0);
		push_req(REQ_WR_VAL, 1, 1, -32'sd5, 0, 0);
		push_req(REQ_WR_VAL, 7, 7, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
		push_query(32'sh00010000, -32'sh00020000);
		push_query(32'sh00030000, 32'sh00020000);
		push_query(32'sh00020000, 32'sd0);
		push_query(32'sh00018001, 32'sh00000003);
		push_query(32'sh0000ffff, 32'sd0);
		push_query(32'sh00030001, 32'sd0);
		push_query(32'sh80000000, 32'sd0);
		push_query(32'sh00020000, 32'sh7fffffff);
		push_query(32'sh00020000, 32'sh80000000);
		push_query(32'sh7fffffff, 32'sh7fffffff);
		// Collapse the slew interval to a single point.
		push_req(REQ_WR_SLEW, 1, 0, 32'sh00010000, 0, 0);
		push_query(32'sh00010000, 32'sd0);

		// Random part over several point-count settings, extremes included.
		run_phase(4'd15, 4'd0, 1'b1);
		run_phase(4'd8, 4'd8, 1'b0);
		run_phase(4'd1, 4'd9, 1'b0);
		run_phase(4'd3, 4'd5, 1'b0);
		run_phase(4'd2, 4'd8, 1'b0);
		run_phase(4'd7, 4'd2, 1'b0);
		run_phase(4'd0, 4'd15, 1'b0);

		wait_idle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
